// ===== rtl/mq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the matrix quadrant sums unit: store geometry, field widths and codes.
// No dependencies; the interfaces and the unit import it.
package mq_pkg;

  localparam int MAX_DIM = 32;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);

  localparam int IDX_W   = 6;
  localparam int ELEM_W  = 16;
  localparam int SUM_W   = 32;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 6'd20;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 6'd20;

  // quadrant code is {south, east}
  localparam logic [1:0] Q_NW = 2'd0;
  localparam logic [1:0] Q_NE = 2'd1;
  localparam logic [1:0] Q_SW = 2'd2;
  localparam logic [1:0] Q_SE = 2'd3;

endpackage

// ===== rtl/mq_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: load or query transactions with valid/ready.
// Depends on mq_pkg.
interface mq_in_if;
  import mq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, cmd, row_index, col_index, element_value, input ready);
  modport sink   (input valid, cmd, row_index, col_index, element_value, output ready);
endinterface

// ===== rtl/mq_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: four quadrant sums and the out-of-range flag with valid/ready.
// Depends on mq_pkg.
interface mq_out_if;
  import mq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_north_west;
  logic signed [SUM_W-1:0] sum_north_east;
  logic signed [SUM_W-1:0] sum_south_west;
  logic signed [SUM_W-1:0] sum_south_east;
  logic                    out_of_range;

  modport source (output valid, sum_north_west, sum_north_east, sum_south_west,
                  sum_south_east, out_of_range, input ready);
  modport sink   (input valid, sum_north_west, sum_north_east, sum_south_west,
                  sum_south_east, out_of_range, output ready);
endinterface

// ===== rtl/mq_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data with valid/ready.
// Depends on mq_pkg.
interface mq_cfg_if;
  import mq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/mq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/matrix_quadrant_sums_unit.sv =====
`timescale 1ns / 1ps
// Matrix quadrant sums unit: element store plus one shared accumulator scan.
// Load: accepted in idle, no result. Query: SCAN walks the nr x nc elements (nr, nc =
// counts saturated to MAX_DIM), then DRAIN, then FINISH loads the result, waiting while
// an earlier result is untaken; a bad pivot or empty matrix goes straight to FINISH. No new
// request is taken before the load. One store read port feeds the single accumulator adder.
// Reset (rst_n low, synchronous): control and counts (20, 20) reset; store undefined.
module matrix_quadrant_sums_unit (
  input  logic clk,
  input  logic rst_n,
  mq_in_if.sink    in_ch,
  mq_out_if.source out_ch,
  mq_cfg_if.sink   cfg_ch
);
  import mq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [CFG_W-1:0] row_count_r, col_count_r;

  // latched pivot and scan counters
  logic [IDX_W-1:0] piv_row_r, piv_row_nxt;
  logic [IDX_W-1:0] piv_col_r, piv_col_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;

  // read tag: travels alongside the RAM's registered read
  logic       tag_v_r, tag_v_nxt;
  logic [1:0] tag_q_r, tag_q_nxt;

  logic signed [SUM_W-1:0] acc_r [4];
  logic                    oor_r, oor_nxt;
  logic                    acc_clr;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_nw_r, out_ne_r, out_sw_r, out_se_r;
  logic                    out_oor_r;
  logic                    out_load;

  // RAM
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ELEM_W-1:0] ram_rdata;

  logic              in_fire;
  logic [CNT_W-1:0]  nr, nc;
  logic [CNT_W-1:0]  i_inc, j_inc;
  logic              row_last, col_last;
  logic              pivot_oor, load_ok;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // counts saturated to the store size
  assign nr = (CMP_W'(row_count_r) > CMP_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(row_count_r);
  assign nc = (CMP_W'(col_count_r) > CMP_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(col_count_r);

  assign pivot_oor = (CMP_W'(in_ch.row_index) > CMP_W'(nr)) ||
                     (CMP_W'(in_ch.col_index) > CMP_W'(nc));
  assign load_ok   = (CMP_W'(in_ch.row_index) < CMP_W'(MAX_DIM)) &&
                     (CMP_W'(in_ch.col_index) < CMP_W'(MAX_DIM));

  assign i_inc    = i_r + CNT_W'(1);
  assign j_inc    = j_r + CNT_W'(1);
  assign row_last = (i_inc == nr);
  assign col_last = (j_inc == nc);

  // loads write straight through in idle; loads outside the store are dropped
  assign ram_we    = in_fire && (in_ch.cmd == CMD_LOAD) && load_ok;
  assign ram_waddr = ADDR_W'(in_ch.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(in_ch.col_index);
  assign ram_re    = (state_r == ST_SCAN);
  assign ram_raddr = ADDR_W'(i_r) * ADDR_W'(MAX_DIM) + ADDR_W'(j_r);

  mq_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.element_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    piv_row_nxt = piv_row_r;
    piv_col_nxt = piv_col_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    tag_v_nxt   = 1'b0;
    tag_q_nxt   = tag_q_r;
    oor_nxt     = oor_r;
    acc_clr     = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.cmd == CMD_QUERY)) begin
          piv_row_nxt = in_ch.row_index;
          piv_col_nxt = in_ch.col_index;
          i_nxt       = '0;
          j_nxt       = '0;
          acc_clr     = 1'b1;
          oor_nxt     = pivot_oor;
          // empty matrix or bad pivot: nothing to walk
          if (pivot_oor || (nr == '0) || (nc == '0)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // pivot row and column are left out of every quadrant
        tag_v_nxt = (CMP_W'(i_r) != CMP_W'(piv_row_r)) &&
                    (CMP_W'(j_r) != CMP_W'(piv_col_r));
        tag_q_nxt = {CMP_W'(i_r) > CMP_W'(piv_row_r), CMP_W'(j_r) > CMP_W'(piv_col_r)};
        if (col_last) begin
          j_nxt = '0;
          i_nxt = i_inc;
          if (row_last) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          j_nxt = j_inc;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
      tag_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_v_r     <= tag_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_ROW_COUNT: row_count_r <= cfg_ch.wdata;
          REG_COL_COUNT: col_count_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath: one shared adder into the selected quadrant accumulator
  always_ff @(posedge clk) begin
    piv_row_r <= piv_row_nxt;
    piv_col_r <= piv_col_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    tag_q_r   <= tag_q_nxt;
    oor_r     <= oor_nxt;
    if (acc_clr) begin
      for (int k = 0; k < 4; k++) begin
        acc_r[k] <= '0;
      end
    end else if (tag_v_r) begin
      acc_r[tag_q_r] <= acc_r[tag_q_r] + SUM_W'($signed(ram_rdata));
    end
    if (out_load) begin
      out_nw_r  <= acc_r[Q_NW];
      out_ne_r  <= acc_r[Q_NE];
      out_sw_r  <= acc_r[Q_SW];
      out_se_r  <= acc_r[Q_SE];
      out_oor_r <= oor_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sum_north_west = out_nw_r;
  assign out_ch.sum_north_east = out_ne_r;
  assign out_ch.sum_south_west = out_sw_r;
  assign out_ch.sum_south_east = out_se_r;
  assign out_ch.out_of_range   = out_oor_r;

  // a pending accumulate always comes from a read issued by the scan
  a_tag_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_v_r |-> $past(state_r == ST_SCAN))
    else $error("accumulate without a scan read");

  // the scan must have drained before the result is taken
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> !tag_v_r)
    else $error("read still in flight at finish");

  a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result shown outside finish");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |->
      (out_nw_r == '0) && (out_ne_r == '0) && (out_sw_r == '0) && (out_se_r == '0))
    else $error("out-of-range result carries sums");

endmodule
